// ----- design/hqwe_pkg.sv -----
// ----------------------------------------------------------------------------
// hqwe_pkg
// Shared types, constants and helpers for the Q encoded-word header encoder.
// ----------------------------------------------------------------------------
package hqwe_pkg;

    localparam int MAX_CHARSET_BYTES = 16;
    localparam int CS_LEN_W          = 5;
    localparam int JOBQ_DEPTH        = 2;
    localparam int JOBQ_PTR_W        = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W        = $clog2(JOBQ_DEPTH + 1);
    localparam int SEQ_IDX_W         = 5;
    localparam int APB_ADDR_W        = 6;
    localparam int APB_DATA_W        = 64;

    localparam logic [2:0] REG_CS_LOW    = 3'd0;
    localparam logic [2:0] REG_CS_HIGH   = 3'd1;
    localparam logic [2:0] REG_CS_LEN    = 3'd2;
    localparam logic [2:0] REG_MAX_LEN   = 3'd3;
    localparam logic [2:0] REG_CTRL_LIM  = 3'd4;

    localparam logic [63:0]         RST_CS_LOW   = 64'd241277752405;
    localparam logic [63:0]         RST_CS_HIGH  = 64'd0;
    localparam logic [CS_LEN_W-1:0] RST_CS_LEN   = 5'd5;
    localparam logic [7:0]          RST_MAX_LEN  = 8'd75;
    localparam logic [6:0]          RST_CTRL_LIM = 7'd20;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [9:0] FRAME_LEN = 10'd7;

    typedef struct packed {
        logic [8*MAX_CHARSET_BYTES-1:0] charset;
        logic [CS_LEN_W-1:0]            name_len;
        logic [7:0]                     max_len;
        logic [6:0]                     ctrl_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       escape;
        logic       open;
        logic       brk;
        logic       last;
    } job_t;

    typedef enum logic [1:0] {
        PH_BREAK,
        PH_OPEN,
        PH_BODY,
        PH_CLOSE
    } phase_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = 8'h30 + {4'd0, nib};
        end
        else
        begin
            d = 8'h37 + {4'd0, nib};
        end
        return d;
    endfunction

endpackage

// ----- design/hqwe_front.sv -----
// ----------------------------------------------------------------------------
// hqwe_front
// Accepts header bytes, classifies them and decides where words open and break.
// ----------------------------------------------------------------------------
module hqwe_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  hqwe_pkg::cfg_t    cfg,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              push,
    output logic              full,
    output hqwe_pkg::job_t    job,
    output logic              job_push,
    input  logic              job_full
);

    logic [7:0] word_length_reg;
    logic [7:0] word_length_next;
    logic       word_open_reg;
    logic       word_open_next;
    logic       escape;
    logic [7:0] need;
    logic [7:0] base_len;
    logic [9:0] total;
    logic       accept;

    assign full   = job_full;
    assign accept = push && !job_full;
    assign job_push = accept;

    always_comb
    begin
        escape = (in_byte != hqwe_pkg::CH_SP) &&
                 ((in_byte == hqwe_pkg::CH_EQ) || (in_byte == hqwe_pkg::CH_QM) ||
                  (in_byte < {1'b0, cfg.ctrl_limit}) || (in_byte >= hqwe_pkg::CH_DEL));
        need  = escape ? 8'd3 : 8'd1;
        total = hqwe_pkg::FRAME_LEN + 10'(cfg.name_len) + 10'(word_length_reg) + 10'(need);

        job.data   = (in_byte == hqwe_pkg::CH_SP) ? hqwe_pkg::CH_US : in_byte;
        job.escape = escape;
        job.open   = !word_open_reg;
        job.brk    = word_open_reg && (word_length_reg != 8'd0) &&
                     (total > 10'(cfg.max_len));
        job.last   = in_last;

        base_len = (job.open || job.brk) ? 8'd0 : word_length_reg;
        word_length_next = in_last ? 8'd0 : 8'(base_len + need);
        word_open_next   = !in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= 8'd0;
            word_open_reg   <= 1'b0;
        end
        else if (accept)
        begin
            word_length_reg <= word_length_next;
            word_open_reg   <= word_open_next;
        end
    end

endmodule

// ----- design/hqwe_job_queue.sv -----
// ----------------------------------------------------------------------------
// hqwe_job_queue
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module hqwe_job_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  hqwe_pkg::job_t    wr_job,
    output logic              q_full,
    input  logic              rd_en,
    output hqwe_pkg::job_t    rd_job,
    output logic              rd_valid
);

    hqwe_pkg::job_t                    mem [hqwe_pkg::JOBQ_DEPTH];
    logic [hqwe_pkg::JOBQ_PTR_W-1:0]   wr_ptr_reg;
    logic [hqwe_pkg::JOBQ_PTR_W-1:0]   rd_ptr_reg;
    logic [hqwe_pkg::JOBQ_CNT_W-1:0]   count_reg;
    logic                              do_wr;
    logic                              do_rd;

    assign q_full   = (count_reg == hqwe_pkg::JOBQ_CNT_W'(hqwe_pkg::JOBQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == hqwe_pkg::JOBQ_PTR_W'(hqwe_pkg::JOBQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == hqwe_pkg::JOBQ_PTR_W'(hqwe_pkg::JOBQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/hqwe_back.sv -----
// ----------------------------------------------------------------------------
// hqwe_back
// Sequencer that expands requests to bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module hqwe_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  hqwe_pkg::cfg_t    cfg,
    input  hqwe_pkg::job_t    job,
    input  logic              job_valid,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              out_run_end,
    output logic              out_header_end
);

    hqwe_pkg::phase_t                  phase_reg;
    hqwe_pkg::phase_t                  phase_next;
    hqwe_pkg::phase_t                  cur_phase;
    hqwe_pkg::phase_t                  seg_phase;
    logic [hqwe_pkg::SEQ_IDX_W-1:0]    idx_reg;
    logic [hqwe_pkg::SEQ_IDX_W-1:0]    idx_next;
    logic [hqwe_pkg::SEQ_IDX_W-1:0]    cur_idx;
    logic                              started_reg;
    logic                              started_next;
    logic                              emit;
    logic [7:0]                        byte_val;
    logic                              seg_end;
    logic                              job_end;
    logic                              hdr_end;
    logic [3:0]                        name_idx;
    logic [hqwe_pkg::SEQ_IDX_W-1:0]    open_end;
    logic [7:0]                        out_byte_reg;
    logic                              out_run_end_reg;
    logic                              out_header_end_reg;
    logic                              out_valid_reg;

    assign emit     = job_valid && (!out_valid_reg || pop);
    assign name_idx = 4'(cur_idx - 5'd2);
    assign open_end = 5'(cfg.name_len + 5'd4);

    always_comb
    begin
        if (started_reg)
        begin
            cur_phase = phase_reg;
            cur_idx   = idx_reg;
        end
        else
        begin
            cur_phase = job.brk ? hqwe_pkg::PH_BREAK :
                        (job.open ? hqwe_pkg::PH_OPEN : hqwe_pkg::PH_BODY);
            cur_idx   = '0;
        end

        byte_val  = hqwe_pkg::CH_QM;
        seg_end   = 1'b0;
        job_end   = 1'b0;
        hdr_end   = 1'b0;
        seg_phase = hqwe_pkg::PH_BODY;

        case (cur_phase)
            hqwe_pkg::PH_BREAK:
            begin
                case (cur_idx)
                    5'd0:    byte_val = hqwe_pkg::CH_QM;
                    5'd1:    byte_val = hqwe_pkg::CH_EQ;
                    5'd2:    byte_val = hqwe_pkg::CH_CR;
                    5'd3:    byte_val = hqwe_pkg::CH_LF;
                    default: byte_val = hqwe_pkg::CH_SP;
                endcase
                seg_end   = (cur_idx == 5'd5);
                seg_phase = hqwe_pkg::PH_OPEN;
            end
            hqwe_pkg::PH_OPEN:
            begin
                if (cur_idx == 5'd0)
                begin
                    byte_val = hqwe_pkg::CH_EQ;
                end
                else if (cur_idx == 5'd1)
                begin
                    byte_val = hqwe_pkg::CH_QM;
                end
                else if (cur_idx < 5'(cfg.name_len + 5'd2))
                begin
                    byte_val = cfg.charset[name_idx*8 +: 8];
                end
                else if (cur_idx == 5'(cfg.name_len + 5'd3))
                begin
                    byte_val = hqwe_pkg::CH_Q;
                end
                else
                begin
                    byte_val = hqwe_pkg::CH_QM;
                end
                seg_end   = (cur_idx == open_end);
                seg_phase = hqwe_pkg::PH_BODY;
            end
            hqwe_pkg::PH_BODY:
            begin
                if (!job.escape)
                begin
                    byte_val = job.data;
                end
                else
                begin
                    case (cur_idx)
                        5'd0:    byte_val = hqwe_pkg::CH_EQ;
                        5'd1:    byte_val = hqwe_pkg::hex_digit(job.data[7:4]);
                        default: byte_val = hqwe_pkg::hex_digit(job.data[3:0]);
                    endcase
                end
                seg_end   = job.escape ? (cur_idx == 5'd2) : 1'b1;
                job_end   = seg_end && !job.last;
                seg_phase = hqwe_pkg::PH_CLOSE;
            end
            hqwe_pkg::PH_CLOSE:
            begin
                byte_val  = (cur_idx == 5'd0) ? hqwe_pkg::CH_QM : hqwe_pkg::CH_EQ;
                seg_end   = (cur_idx == 5'd1);
                job_end   = seg_end;
                hdr_end   = seg_end;
                seg_phase = hqwe_pkg::PH_CLOSE;
            end
            default:
            begin
                byte_val = hqwe_pkg::CH_QM;
            end
        endcase

        phase_next   = phase_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        job_pop      = 1'b0;
        if (emit)
        begin
            if (job_end)
            begin
                started_next = 1'b0;
                job_pop      = 1'b1;
            end
            else if (seg_end)
            begin
                phase_next   = seg_phase;
                idx_next     = '0;
                started_next = 1'b1;
            end
            else
            begin
                phase_next   = cur_phase;
                idx_next     = cur_idx + 1'b1;
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hqwe_pkg::PH_BODY;
            idx_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg       <= byte_val;
            out_run_end_reg    <= job_end;
            out_header_end_reg <= hdr_end;
        end
    end

    assign empty          = !out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_run_end    = out_run_end_reg;
    assign out_header_end = out_header_end_reg;

endmodule

// ----- design/header_q_word_encoder.sv -----
// ----------------------------------------------------------------------------
// header_q_word_encoder
// Streams header bytes into Q encoded words with framing and line folding.
// ----------------------------------------------------------------------------
// The output side delivers one encoded byte per clock while pop is held and a
// request is queued. A request produces one output byte for a plain byte,
// three for an escaped byte, plus five and the charset name length when a word
// opens, eleven plus the name length when a word is folded, and two when the
// header closes. That output sequencer sets the sustained rate; the input side
// accepts a byte every cycle until the two-entry request queue fills.
module header_q_word_encoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hqwe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hqwe_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hqwe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic [7:0]                          in_byte,
    input  logic                                in_last,
    input  logic                                push,
    output logic                                full,
    output logic [7:0]                          out_byte,
    output logic                                out_run_end,
    output logic                                out_header_end,
    output logic                                empty,
    input  logic                                pop
);

    logic [63:0]                    cs_low_reg;
    logic [63:0]                    cs_high_reg;
    logic [hqwe_pkg::CS_LEN_W-1:0]  cs_len_reg;
    logic [7:0]                     max_len_reg;
    logic [6:0]                     ctrl_lim_reg;
    logic [2:0]                     reg_idx;
    logic                           wr_en;
    hqwe_pkg::cfg_t                 cfg;
    hqwe_pkg::job_t                 front_job;
    hqwe_pkg::job_t                 head_job;
    logic                           job_push;
    logic                           job_full;
    logic                           job_valid;
    logic                           job_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hqwe_pkg::APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_low_reg   <= hqwe_pkg::RST_CS_LOW;
            cs_high_reg  <= hqwe_pkg::RST_CS_HIGH;
            cs_len_reg   <= hqwe_pkg::RST_CS_LEN;
            max_len_reg  <= hqwe_pkg::RST_MAX_LEN;
            ctrl_lim_reg <= hqwe_pkg::RST_CTRL_LIM;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                hqwe_pkg::REG_CS_LOW:   cs_low_reg   <= pwdata;
                hqwe_pkg::REG_CS_HIGH:  cs_high_reg  <= pwdata;
                hqwe_pkg::REG_CS_LEN:   cs_len_reg   <= pwdata[hqwe_pkg::CS_LEN_W-1:0];
                hqwe_pkg::REG_MAX_LEN:  max_len_reg  <= pwdata[7:0];
                hqwe_pkg::REG_CTRL_LIM: ctrl_lim_reg <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            hqwe_pkg::REG_CS_LOW:   prdata = cs_low_reg;
            hqwe_pkg::REG_CS_HIGH:  prdata = cs_high_reg;
            hqwe_pkg::REG_CS_LEN:   prdata = 64'(cs_len_reg);
            hqwe_pkg::REG_MAX_LEN:  prdata = 64'(max_len_reg);
            hqwe_pkg::REG_CTRL_LIM: prdata = 64'(ctrl_lim_reg);
            default:                prdata = '0;
        endcase
    end

    // Name lengths above the byte capacity saturate.
    always_comb
    begin
        cfg.charset    = {cs_high_reg, cs_low_reg};
        cfg.name_len   = (cs_len_reg > hqwe_pkg::CS_LEN_W'(hqwe_pkg::MAX_CHARSET_BYTES)) ?
                         hqwe_pkg::CS_LEN_W'(hqwe_pkg::MAX_CHARSET_BYTES) : cs_len_reg;
        cfg.max_len    = max_len_reg;
        cfg.ctrl_limit = ctrl_lim_reg;
    end

    hqwe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .full     (full),
        .job      (front_job),
        .job_push (job_push),
        .job_full (job_full)
    );

    hqwe_job_queue u_job_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (front_job),
        .q_full   (job_full),
        .rd_en    (job_pop),
        .rd_job   (head_job),
        .rd_valid (job_valid)
    );

    hqwe_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .job            (head_job),
        .job_valid      (job_valid),
        .job_pop        (job_pop),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .out_run_end    (out_run_end),
        .out_header_end (out_header_end)
    );

    a_hdr_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_header_end) |-> out_run_end)
        else $error("Header end without end of request.");

    a_hdr_end_is_equals: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_header_end) |-> (out_byte == hqwe_pkg::CH_EQ))
        else $error("Header end not on the closing equals sign.");

    a_run_end_is_text: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_run_end && !out_header_end) |->
        ((out_byte != hqwe_pkg::CH_EQ) && (out_byte != hqwe_pkg::CH_QM)))
        else $error("Request ends on a framing character.");

endmodule
